@@ hw/rtl/rbs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths, codes, command/status types and saturation helpers for the
// red-black SOR sweep engine.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int VALUE_BITS = 48;
    localparam int FRAC_BITS  = 24;

    localparam int COL_BITS   = 6;
    localparam int ROW_BITS   = 6;
    localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int GRID_BITS  = 7;
    localparam int DIAG_BITS  = 47;
    localparam int W_BITS     = 25;
    localparam int INV_BITS   = 47;
    localparam int NORM_BITS  = 64;
    localparam int SUM_BITS   = VALUE_BITS + 2;
    localparam int MUL_BITS   = 64;
    localparam int HALF_BITS  = MUL_BITS / 2;
    localparam int PROD_BITS  = 2 * MUL_BITS;
    localparam int DIV_BITS   = 73;
    localparam int DCNT_BITS  = 7;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_SWEEP = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RELAX       = 2'd2;
    localparam logic [1:0] CFG_INV_SPACING = 2'd3;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_TAKE_READ,
        OP_TAKE_CENTER,
        OP_SUM_FIRST,
        OP_SUM_ADD,
        OP_MUL_LAP,
        OP_LAP,
        OP_T,
        OP_MUL_GAIN,
        OP_DIV,
        OP_GAIN,
        OP_MUL_KEEP,
        OP_KEEP,
        OP_NEW,
        OP_MUL_SQ,
        OP_NORM,
        OP_STORE
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [ADDR_BITS-1:0] addr;
        logic                 wr_in;
        logic                 load_out;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic diag_zero;
    } t_stat;

    function automatic t_value sat_value(input logic signed [SUM_BITS-1:0] x);
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        t_value                     res;
        hi = {{(SUM_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            res = hi[VALUE_BITS-1:0];
        end else if (x < lo) begin
            res = lo[VALUE_BITS-1:0];
        end else begin
            res = x[VALUE_BITS-1:0];
        end
        return res;
    endfunction

    function automatic t_value sat_mag(input logic [PROD_BITS-1:0] mag, input logic neg);
        logic [PROD_BITS-1:0]  lim;
        logic [VALUE_BITS-1:0] m;
        lim = {{(PROD_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}}
            + PROD_BITS'(neg);
        m = (mag > lim) ? lim[VALUE_BITS-1:0] : mag[VALUE_BITS-1:0];
        return neg ? signed'(~m + 1'b1) : signed'(m);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rbs_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_in_if
// Item channel into the sweep engine: valid/ready plus one cell command.
// ----------------------------------------------------------------------------
interface rbs_in_if;
    import rbs_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [ADDR_BITS-1:0]        cell_index;
    logic signed [VALUE_BITS-1:0] cell_value;
    logic signed [VALUE_BITS-1:0] rhs_value;
    logic [DIAG_BITS-1:0]        diag_value;

    modport source (output valid, action, cell_index, cell_value, rhs_value, diag_value,
                    input ready);
    modport sink   (input valid, action, cell_index, cell_value, rhs_value, diag_value,
                    output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rbs_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_out_if
// Result channel out of the sweep engine: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface rbs_out_if;
    import rbs_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [VALUE_BITS-1:0] read_value;
    logic [NORM_BITS-1:0]        sweep_norm;
    logic                        norm_saturated;

    modport source (output valid, read_value, sweep_norm, norm_saturated, input ready);
    modport sink   (input valid, read_value, sweep_norm, norm_saturated, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rbs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/rbs_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_datapath
// Cell stores, neighbour sum, shared 32x32 iterative multiplier, bit-serial
// divider, saturation and norm accumulation, result register.
// ----------------------------------------------------------------------------
module rbs_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rbs_pkg::t_cmd                 i_cmd,
    output rbs_pkg::t_stat                     o_stat,
    input  wire logic signed [rbs_pkg::VALUE_BITS-1:0] i_cell_value,
    input  wire logic signed [rbs_pkg::VALUE_BITS-1:0] i_rhs_value,
    input  wire logic [rbs_pkg::DIAG_BITS-1:0] i_diag_value,
    input  wire logic [rbs_pkg::W_BITS-1:0]    i_relax_factor,
    input  wire logic [rbs_pkg::INV_BITS-1:0]  i_inv_spacing_sq,
    output logic signed [rbs_pkg::VALUE_BITS-1:0] o_read_value,
    output logic [rbs_pkg::NORM_BITS-1:0]      o_sweep_norm,
    output logic                               o_norm_saturated
);
    import rbs_pkg::*;

    logic [VALUE_BITS-1:0] sol_q;
    logic [VALUE_BITS-1:0] rhs_q;
    logic [DIAG_BITS-1:0]  diag_q;
    logic                  sol_we;
    logic [VALUE_BITS-1:0] sol_wdata;

    t_value                     r_old, r_rhs, r_lap, r_t, r_gain, r_keep, r_nv, r_rd;
    logic [DIAG_BITS-1:0]       r_diag;
    logic signed [SUM_BITS-1:0] r_sum;
    logic [NORM_BITS-1:0]       r_norm;
    logic                       r_sat;

    logic [MUL_BITS-1:0]  r_ma, r_mb;
    logic [PROD_BITS-1:0] r_acc;
    logic [1:0]           r_mstep;
    logic                 r_mbusy;

    logic [DIV_BITS-1:0]  r_dn, r_q;
    logic [DIAG_BITS-1:0] r_rem;
    logic [DCNT_BITS-1:0] r_dcnt;
    logic                 r_dbusy;

    t_value                     r_out_read;
    logic [NORM_BITS-1:0]       r_out_norm;
    logic                       r_out_sat;

    logic [HALF_BITS-1:0]       pa, pb;
    logic [MUL_BITS-1:0]        pp;
    logic [PROD_BITS-1:0]       pp_sh;
    logic [DIAG_BITS:0]         rem_sh;
    logic                       q_bit;
    logic [DIAG_BITS-1:0]       rem_nx;
    logic signed [SUM_BITS-1:0] sol_ext;
    logic [SUM_BITS-1:0]        sum_mag;
    logic [VALUE_BITS-1:0]      t_mag, old_mag;
    logic signed [W_BITS:0]     coef;
    logic [W_BITS:0]            coef_mag;
    logic signed [SUM_BITS-1:0] dif;
    logic [SUM_BITS-1:0]        dif_mag;
    logic [NORM_BITS:0]         norm_sum;

    assign sol_we    = i_cmd.wr_in | (i_cmd.op == OP_STORE);
    assign sol_wdata = i_cmd.wr_in ? i_cell_value : r_nv;

    rbs_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_sol (
        .i_clk(i_clk), .i_we(sol_we), .i_waddr(i_cmd.addr), .i_wdata(sol_wdata),
        .i_raddr(i_cmd.addr), .o_rdata(sol_q)
    );
    rbs_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_rhs (
        .i_clk(i_clk), .i_we(i_cmd.wr_in), .i_waddr(i_cmd.addr), .i_wdata(i_rhs_value),
        .i_raddr(i_cmd.addr), .o_rdata(rhs_q)
    );
    rbs_ram #(.WIDTH(DIAG_BITS), .DEPTH(CELLS)) u_diag (
        .i_clk(i_clk), .i_we(i_cmd.wr_in), .i_waddr(i_cmd.addr), .i_wdata(i_diag_value),
        .i_raddr(i_cmd.addr), .o_rdata(diag_q)
    );

    always_comb begin
        pa = r_mstep[0] ? r_ma[MUL_BITS-1:HALF_BITS] : r_ma[HALF_BITS-1:0];
        pb = r_mstep[1] ? r_mb[MUL_BITS-1:HALF_BITS] : r_mb[HALF_BITS-1:0];
        pp = pa * pb;
        unique case (r_mstep)
            2'd0:    pp_sh = PROD_BITS'(pp);
            2'd3:    pp_sh = {pp, {MUL_BITS{1'b0}}};
            default: pp_sh = PROD_BITS'(pp) << HALF_BITS;
        endcase

        rem_sh = {r_rem, r_dn[DIV_BITS-1]};
        q_bit  = rem_sh >= {1'b0, r_diag};
        rem_nx = q_bit ? DIAG_BITS'(rem_sh - {1'b0, r_diag}) : rem_sh[DIAG_BITS-1:0];

        sol_ext  = SUM_BITS'(signed'(sol_q));
        sum_mag  = r_sum[SUM_BITS-1] ? unsigned'(-r_sum) : unsigned'(r_sum);
        t_mag    = r_t[VALUE_BITS-1] ? unsigned'(-r_t) : unsigned'(r_t);
        old_mag  = r_old[VALUE_BITS-1] ? unsigned'(-r_old) : unsigned'(r_old);
        coef     = (W_BITS+1)'(1 << FRAC_BITS) - signed'({1'b0, i_relax_factor});
        coef_mag = coef[W_BITS] ? unsigned'(-coef) : unsigned'(coef);
        dif      = SUM_BITS'(r_nv) - SUM_BITS'(r_old);
        dif_mag  = dif[SUM_BITS-1] ? unsigned'(-dif) : unsigned'(dif);
        norm_sum = {1'b0, r_norm} + {1'b0, r_acc[NORM_BITS-1:0]};
    end

    assign o_stat.busy      = r_mbusy | r_dbusy;
    assign o_stat.diag_zero = (r_diag == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_dbusy <= 1'b0;
        end else begin
            if (r_mbusy) begin
                r_acc   <= r_acc + pp_sh;
                r_mstep <= r_mstep + 2'd1;
                if (r_mstep == 2'd3) begin
                    r_mbusy <= 1'b0;
                end
            end
            if (r_dbusy) begin
                r_rem <= rem_nx;
                r_q   <= {r_q[DIV_BITS-2:0], q_bit};
                r_dn  <= {r_dn[DIV_BITS-2:0], 1'b0};
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == '0) begin
                    r_dbusy <= 1'b0;
                end
            end
            unique case (i_cmd.op)
                OP_MUL_LAP, OP_MUL_GAIN, OP_MUL_KEEP, OP_MUL_SQ: begin
                    r_acc   <= '0;
                    r_mstep <= 2'd0;
                    r_mbusy <= 1'b1;
                end
                OP_DIV: begin
                    r_dn    <= r_acc[DIV_BITS-1:0];
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_dcnt  <= DCNT_BITS'(DIV_BITS - 1);
                    r_dbusy <= 1'b1;
                end
                default: begin
                end
            endcase
        end

        unique case (i_cmd.op)
            OP_CLEAR: begin
                r_rd   <= '0;
                r_norm <= '0;
                r_sat  <= 1'b0;
            end
            OP_TAKE_READ: r_rd <= sol_q;
            OP_TAKE_CENTER: begin
                r_old  <= sol_q;
                r_rhs  <= rhs_q;
                r_diag <= diag_q;
            end
            OP_SUM_FIRST: r_sum <= sol_ext;
            OP_SUM_ADD:   r_sum <= r_sum + sol_ext;
            OP_MUL_LAP: begin
                r_ma <= MUL_BITS'(sum_mag);
                r_mb <= MUL_BITS'(i_inv_spacing_sq);
            end
            OP_LAP: r_lap <= sat_mag(r_acc >> FRAC_BITS, r_sum[SUM_BITS-1]);
            OP_T:   r_t   <= sat_value(SUM_BITS'(r_lap) - SUM_BITS'(r_rhs));
            OP_MUL_GAIN: begin
                r_ma <= MUL_BITS'(t_mag);
                r_mb <= MUL_BITS'(i_relax_factor);
            end
            OP_GAIN: r_gain <= sat_mag(PROD_BITS'(r_q), r_t[VALUE_BITS-1]);
            OP_MUL_KEEP: begin
                r_ma <= MUL_BITS'(coef_mag);
                r_mb <= MUL_BITS'(old_mag);
            end
            OP_KEEP: r_keep <= sat_mag(r_acc >> FRAC_BITS, coef[W_BITS] ^ r_old[VALUE_BITS-1]);
            OP_NEW:  r_nv   <= sat_value(SUM_BITS'(r_keep) + SUM_BITS'(r_gain));
            OP_MUL_SQ: begin
                r_ma <= MUL_BITS'(dif_mag);
                r_mb <= MUL_BITS'(dif_mag);
            end
            OP_NORM: begin
                if ((r_acc[PROD_BITS-1:NORM_BITS] != '0) || norm_sum[NORM_BITS]) begin
                    r_norm <= '1;
                    r_sat  <= 1'b1;
                end else begin
                    r_norm <= norm_sum[NORM_BITS-1:0];
                end
            end
            default: begin
            end
        endcase

        if (i_cmd.load_out) begin
            r_out_read <= r_rd;
            r_out_norm <= r_norm;
            r_out_sat  <= r_sat;
        end
    end

    assign o_read_value     = r_out_read;
    assign o_sweep_norm     = r_out_norm;
    assign o_norm_saturated = r_out_sat;
endmodule
`default_nettype wire

@@ hw/rtl/rbs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rbs_ctrl
// Item sequencer: decodes actions, scans red then black interior cells and
// steps the datapath through one relaxation per nonzero-diagonal cell.
// ----------------------------------------------------------------------------
module rbs_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_action,
    input  wire logic [rbs_pkg::ADDR_BITS-1:0]  i_index,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [rbs_pkg::GRID_BITS-1:0]  i_grid_width,
    input  wire logic [rbs_pkg::GRID_BITS-1:0]  i_grid_height,
    input  wire rbs_pkg::t_stat                 i_stat,
    output rbs_pkg::t_cmd                       o_cmd
);
    import rbs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_SCAN, S_K, S_L, S_R, S_U, S_D, S_LAST,
        S_M1, S_W1, S_T, S_M2, S_W2, S_WD, S_M3, S_W3, S_NV, S_M4, S_W4, S_ST,
        S_RESP
    } t_state;

    t_state               r_state, n_state;
    logic [GRID_BITS-1:0] r_col, n_col, r_row, n_row;
    logic                 r_pass, n_pass;
    logic                 r_out_valid, n_out_valid;
    logic [GRID_BITS-1:0] gw, gh;
    logic [COL_BITS-1:0]  c;
    logic [ROW_BITS-1:0]  rw;

    assign gw = (i_grid_width  > GRID_BITS'(MAX_WIDTH))  ? GRID_BITS'(MAX_WIDTH)  : i_grid_width;
    assign gh = (i_grid_height > GRID_BITS'(MAX_HEIGHT)) ? GRID_BITS'(MAX_HEIGHT) : i_grid_height;
    assign c  = r_col[COL_BITS-1:0];
    assign rw = r_row[ROW_BITS-1:0];

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_pass    = r_pass;
        o_cmd.op       = OP_NONE;
        o_cmd.addr     = {rw, c};
        o_cmd.wr_in    = 1'b0;
        o_cmd.load_out = 1'b0;
        o_in_ready     = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                o_cmd.addr = i_index;
                if (i_in_valid) begin
                    o_cmd.op    = OP_CLEAR;
                    o_cmd.wr_in = (i_action == ACT_WRITE);
                    priority if (i_action == ACT_READ) begin
                        n_state = S_READ;
                    end else if (i_action == ACT_SWEEP) begin
                        n_pass  = 1'b0;
                        n_row   = GRID_BITS'(1);
                        n_col   = GRID_BITS'(1);
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_READ: begin
                o_cmd.op = OP_TAKE_READ;
                n_state  = S_RESP;
            end
            S_SCAN: begin
                priority if (({1'b0, r_row} + 1'b1) >= {1'b0, gh}) begin
                    if (r_pass) begin
                        n_state = S_RESP;
                    end else begin
                        n_pass = 1'b1;
                        n_row  = GRID_BITS'(1);
                        n_col  = GRID_BITS'(2);
                    end
                end else if (({1'b0, r_col} + 1'b1) >= {1'b0, gw}) begin
                    n_row = r_row + 1'b1;
                    n_col = (~r_row[0] ^ r_pass) ? GRID_BITS'(1) : GRID_BITS'(2);
                end else begin
                    n_state = S_K;
                end
            end
            S_K: n_state = S_L;
            S_L: begin
                o_cmd.addr = {rw, c - 1'b1};
                o_cmd.op   = OP_TAKE_CENTER;
                n_state    = S_R;
            end
            S_R: begin
                o_cmd.addr = {rw, c + 1'b1};
                o_cmd.op   = OP_SUM_FIRST;
                n_state    = S_U;
            end
            S_U: begin
                o_cmd.addr = {rw - 1'b1, c};
                o_cmd.op   = OP_SUM_ADD;
                n_state    = S_D;
            end
            S_D: begin
                o_cmd.addr = {rw + 1'b1, c};
                o_cmd.op   = OP_SUM_ADD;
                n_state    = S_LAST;
            end
            S_LAST: begin
                o_cmd.op = OP_SUM_ADD;
                if (i_stat.diag_zero) begin
                    n_col   = r_col + GRID_BITS'(2);
                    n_state = S_SCAN;
                end else begin
                    n_state = S_M1;
                end
            end
            S_M1: begin
                o_cmd.op = OP_MUL_LAP;
                n_state  = S_W1;
            end
            S_W1: begin
                if (!i_stat.busy) begin
                    o_cmd.op = OP_LAP;
                    n_state  = S_T;
                end
            end
            S_T: begin
                o_cmd.op = OP_T;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = OP_MUL_GAIN;
                n_state  = S_W2;
            end
            S_W2: begin
                if (!i_stat.busy) begin
                    o_cmd.op = OP_DIV;
                    n_state  = S_WD;
                end
            end
            S_WD: begin
                if (!i_stat.busy) begin
                    o_cmd.op = OP_GAIN;
                    n_state  = S_M3;
                end
            end
            S_M3: begin
                o_cmd.op = OP_MUL_KEEP;
                n_state  = S_W3;
            end
            S_W3: begin
                if (!i_stat.busy) begin
                    o_cmd.op = OP_KEEP;
                    n_state  = S_NV;
                end
            end
            S_NV: begin
                o_cmd.op = OP_NEW;
                n_state  = S_M4;
            end
            S_M4: begin
                o_cmd.op = OP_MUL_SQ;
                n_state  = S_W4;
            end
            S_W4: begin
                if (!i_stat.busy) begin
                    o_cmd.op = OP_NORM;
                    n_state  = S_ST;
                end
            end
            S_ST: begin
                o_cmd.op = OP_STORE;
                n_col    = r_col + GRID_BITS'(2);
                n_state  = S_SCAN;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = o_cmd.load_out | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_pass      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pass      <= n_pass;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

@@ hw/rtl/red_black_sor_sweep.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// red_black_sor_sweep
// Red-black SOR sweep engine for a 2D Poisson grid in signed Q23.24.
//
//   channel  dir  handshake      beat
//   i_in     in   valid/ready    action, cell_index, cell/rhs/diag values
//   o_out    out  valid/ready    read_value, sweep_norm, norm_saturated
//   i_cfg_*  in   write enable   register index, data
//
// Write and unused actions go straight to the response state; a read first
// passes through a read state. Sweep time per interior cell is set by five
// serial reads of the solution RAM port, four 4-step passes of the shared
// 32x32 multiplier and a 73-step divider; zero-diagonal cells skip both.
// One item at a time; a result waits in the output register while the next
// item is accepted. Synchronous active-low reset; stores hold no reset.
// ----------------------------------------------------------------------------
module red_black_sor_sweep (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rbs_in_if.sink                             i_in,
    rbs_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [rbs_pkg::INV_BITS-1:0]  i_cfg_data
);
    import rbs_pkg::*;

    logic [GRID_BITS-1:0] r_grid_width, r_grid_height;
    logic [W_BITS-1:0]    r_relax_factor;
    logic [INV_BITS-1:0]  r_inv_spacing_sq;
    t_cmd                 cmd;
    t_stat                stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width     <= GRID_BITS'(64);
            r_grid_height    <= GRID_BITS'(64);
            r_relax_factor   <= W_BITS'(29360128);
            r_inv_spacing_sq <= INV_BITS'(64'd26843545600);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width     <= i_cfg_data[GRID_BITS-1:0];
                CFG_GRID_HEIGHT: r_grid_height    <= i_cfg_data[GRID_BITS-1:0];
                CFG_RELAX:       r_relax_factor   <= i_cfg_data[W_BITS-1:0];
                CFG_INV_SPACING: r_inv_spacing_sq <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rbs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (i_in.ready),
        .i_action      (i_in.action),
        .i_index       (i_in.cell_index),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    rbs_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cell_value     (i_in.cell_value),
        .i_rhs_value      (i_in.rhs_value),
        .i_diag_value     (i_in.diag_value),
        .i_relax_factor   (r_relax_factor),
        .i_inv_spacing_sq (r_inv_spacing_sq),
        .o_read_value     (o_out.read_value),
        .o_sweep_norm     (o_out.sweep_norm),
        .o_norm_saturated (o_out.norm_saturated)
    );
endmodule
`default_nettype wire

@@ tb/red_black_sor_sweep_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// red_black_sor_sweep_tb
// Self-checking bench for the red-black SOR sweep engine. Cell writes, reads,
// sweeps and unused actions are sent over the item channel. A bit-exact grid
// model predicts every result beat, and the checker compares each beat with
// the oldest prediction. Grid size, weight and spacing registers are changed
// between phases. Both channels stall at random outside the steady-stream phase.
// ----------------------------------------------------------------------------
module red_black_sor_sweep_tb;
    import rbs_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 200000;
    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef struct {
        logic [1:0]                   act;
        logic [ADDR_BITS-1:0]         idx;
        logic signed [VALUE_BITS-1:0] cv;
        logic signed [VALUE_BITS-1:0] rv;
        logic [DIAG_BITS-1:0]         dv;
    } cell_cmd_t;

    typedef struct {
        logic signed [VALUE_BITS-1:0] rd;
        logic [NORM_BITS-1:0]         norm;
        logic                         sat;
    } cell_result_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [INV_BITS-1:0] i_cfg_data;

    rbs_in_if  in_ch ();
    rbs_out_if out_ch ();

    red_black_sor_sweep i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // grid model
    logic signed [VALUE_BITS-1:0] sol_m [CELLS];
    logic signed [VALUE_BITS-1:0] rhs_m [CELLS];
    logic [DIAG_BITS-1:0]         diag_m [CELLS];
    bit                           loaded [CELLS];
    int                           loaded_list [$];
    logic [GRID_BITS-1:0]         width_m;
    logic [GRID_BITS-1:0]         height_m;
    logic [W_BITS-1:0]            relax_m;
    logic [INV_BITS-1:0]          inv_m;

    cell_result_t pending_results [$];
    int  errors;
    int  n_writes, n_reads, n_sweeps, n_sat, n_checked;
    bit  stall_en;
    int  quiet_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        i_clk            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_WRITE;
        in_ch.cell_index = '0;
        in_ch.cell_value = '0;
        in_ch.rhs_value  = '0;
        in_ch.diag_value = '0;
        out_ch.ready     = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_GRID_WIDTH;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= stall_en ? ($urandom_range(99) >= 11) : 1'b1;
    end

    function automatic logic signed [VALUE_BITS-1:0] clamp_value(longint x);
        if (x > longint'(VMAX)) return VMAX;
        if (x < longint'(VMIN)) return VMIN;
        return x[VALUE_BITS-1:0];
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] clamp_mag(logic [127:0] mag, bit neg);
        logic [127:0] lim;
        lim = {80'b0, 48'h7FFF_FFFF_FFFF} + 128'(neg);
        if (mag > lim) mag = lim;
        return neg ? -mag[VALUE_BITS-1:0] : mag[VALUE_BITS-1:0];
    endfunction

    function automatic logic [63:0] abs64(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic void relax_cell(int c, int r, ref logic [NORM_BITS-1:0] norm,
                                       ref bit sat);
        int k;
        longint sum, coef, old;
        logic signed [VALUE_BITS-1:0] lap, t, gain, keep, nv;
        logic [127:0] p, sq;
        logic [63:0] d;
        k = c + r * MAX_WIDTH;
        if (diag_m[k] == 0) return;
        old = longint'(sol_m[k]);
        sum = longint'(sol_m[k-1]) + longint'(sol_m[k+1])
            + longint'(sol_m[k-MAX_WIDTH]) + longint'(sol_m[k+MAX_WIDTH]);
        p = ({64'b0, abs64(sum)} * {81'b0, inv_m}) >> FRAC_BITS;
        lap = clamp_mag(p, sum < 0);
        t = clamp_value(longint'(lap) - longint'(rhs_m[k]));
        p = ({64'b0, abs64(longint'(t))} * {103'b0, relax_m}) / {81'b0, diag_m[k]};
        gain = clamp_mag(p, t < 0);
        coef = (64'sd1 <<< FRAC_BITS) - longint'({39'b0, relax_m});
        p = ({64'b0, abs64(coef)} * {64'b0, abs64(old)}) >> FRAC_BITS;
        keep = clamp_mag(p, (coef < 0) != (old < 0));
        nv = clamp_value(longint'(keep) + longint'(gain));
        d = abs64(longint'(nv) - old);
        sq = {64'b0, d} * {64'b0, d};
        if (sq[127:64] != 0 || ({1'b0, norm} + {1'b0, sq[63:0]}) > {1'b0, {64{1'b1}}}) begin
            norm = '1;
            sat = 1'b1;
        end else begin
            norm = norm + sq[63:0];
        end
        sol_m[k] = nv;
    endfunction

    function automatic cell_result_t predict_cell_result(cell_cmd_t cmd);
        cell_result_t res;
        int gw, gh;
        logic [NORM_BITS-1:0] norm;
        bit sat;
        res = '{rd: '0, norm: '0, sat: 1'b0};
        case (cmd.act)
            ACT_WRITE: begin
                sol_m[cmd.idx]  = cmd.cv;
                rhs_m[cmd.idx]  = cmd.rv;
                diag_m[cmd.idx] = cmd.dv;
                if (!loaded[cmd.idx]) begin
                    loaded[cmd.idx] = 1'b1;
                    loaded_list.push_back(cmd.idx);
                end
                n_writes++;
            end
            ACT_READ: begin
                res.rd = sol_m[cmd.idx];
                n_reads++;
            end
            ACT_SWEEP: begin
                gw = width_m > MAX_WIDTH ? MAX_WIDTH : width_m;
                gh = height_m > MAX_HEIGHT ? MAX_HEIGHT : height_m;
                norm = '0;
                sat = 1'b0;
                for (int pass = 0; pass < 2; pass++)
                    for (int r = 1; r + 1 < gh; r++)
                        for (int c = 1; c + 1 < gw; c++)
                            if (((c + r) & 1) == pass) relax_cell(c, r, norm, sat);
                res.norm = norm;
                res.sat = sat;
                n_sweeps++;
                if (sat) n_sat++;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_cell_cmd(cell_cmd_t cmd);
        while (stall_en && $urandom_range(99) < 11) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= cmd.act;
        in_ch.cell_index <= cmd.idx;
        in_ch.cell_value <= cmd.cv;
        in_ch.rhs_value  <= cmd.rv;
        in_ch.diag_value <= cmd.dv;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_cell_result(cmd));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [INV_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_GRID_WIDTH:  width_m  = data[GRID_BITS-1:0];
            CFG_GRID_HEIGHT: height_m = data[GRID_BITS-1:0];
            CFG_RELAX:       relax_m  = data[W_BITS-1:0];
            default:         inv_m    = data;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_grid(int w, int h);
        write_reg(CFG_GRID_WIDTH, INV_BITS'(w));
        write_reg(CFG_GRID_HEIGHT, INV_BITS'(h));
    endtask

    function automatic logic signed [VALUE_BITS-1:0] rand_value(bit wild);
        logic signed [31:0] s;
        s = $urandom;
        case (wild ? $urandom_range(5) : $urandom_range(9) + 6)
            0: return VMAX;
            1: return VMIN;
            2: return '0;
            3, 4, 5: return VALUE_BITS'({$urandom, $urandom});
            default: return VALUE_BITS'(s >>> 4);
        endcase
    endfunction

    function automatic logic [DIAG_BITS-1:0] rand_diag(bit wild);
        case ($urandom_range(wild ? 4 : 9))
            0: return '0;
            1: return '1;
            2: return DIAG_BITS'(1);
            3: return DIAG_BITS'({$urandom, $urandom});
            default: return DIAG_BITS'(64'd6400 << FRAC_BITS)
                          + DIAG_BITS'($urandom_range(0, 1 << 30));
        endcase
    endfunction

    function automatic cell_cmd_t write_cmd(int idx, bit wild);
        cell_cmd_t cmd;
        cmd.act = ACT_WRITE;
        cmd.idx = ADDR_BITS'(idx);
        cmd.cv  = rand_value(wild);
        cmd.rv  = rand_value(wild);
        cmd.dv  = rand_diag(wild);
        return cmd;
    endfunction

    function automatic cell_cmd_t plain_cmd(logic [1:0] act, int idx);
        cell_cmd_t cmd;
        cmd.act = act;
        cmd.idx = ADDR_BITS'(idx);
        cmd.cv  = VALUE_BITS'({$urandom, $urandom});
        cmd.rv  = VALUE_BITS'({$urandom, $urandom});
        cmd.dv  = DIAG_BITS'({$urandom, $urandom});
        return cmd;
    endfunction

    task automatic fill_grid(int w, int h, bit wild);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_cell_cmd(write_cmd(c + r * MAX_WIDTH, wild));
    endtask

    task automatic read_any();
        send_cell_cmd(plain_cmd(ACT_READ,
            loaded_list[$urandom_range(loaded_list.size() - 1)]));
    endtask

    // reset weight and spacing on a 7x3 strip
    task automatic test_wide_strip();
        set_grid(7, 3);
        fill_grid(7, 3, 1'b0);
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        for (int i = 0; i < 4; i++) read_any();
        wait_drained();
    endtask

    task automatic test_extremes();
        cell_cmd_t cmd;
        set_grid(3, 3);
        write_reg(CFG_RELAX, '1);
        write_reg(CFG_INV_SPACING, '1);
        for (int k = 0; k < 9; k++) begin
            cmd = plain_cmd(ACT_WRITE, (k % 3) + (k / 3) * MAX_WIDTH);
            cmd.cv = (k == 4) ? VMIN : VMAX;
            cmd.rv = VMIN;
            cmd.dv = DIAG_BITS'(1);
            send_cell_cmd(cmd);
        end
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        send_cell_cmd(plain_cmd(ACT_READ, 1 + MAX_WIDTH));
        send_cell_cmd(plain_cmd(ACT_UNUSED, 1 + MAX_WIDTH));
        cmd = plain_cmd(ACT_WRITE, 1 + MAX_WIDTH);
        cmd.cv = VMAX;
        cmd.rv = VMAX;
        cmd.dv = '1;
        send_cell_cmd(cmd);
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        cmd.cv = VMIN;
        cmd.dv = '0;
        send_cell_cmd(cmd);
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        send_cell_cmd(plain_cmd(ACT_READ, 1 + MAX_WIDTH));
        wait_drained();
        write_reg(CFG_RELAX, '0);
        write_reg(CFG_INV_SPACING, '0);
        send_cell_cmd(write_cmd(1 + MAX_WIDTH, 1'b1));
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        send_cell_cmd(plain_cmd(ACT_READ, 1 + MAX_WIDTH));
        wait_drained();
        // degenerate grids sweep nothing
        set_grid(2, 3);
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        wait_drained();
        set_grid(0, 0);
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        wait_drained();
        write_reg(CFG_RELAX, INV_BITS'(25'd16777216));
        write_reg(CFG_INV_SPACING, 47'd26843545600);
    endtask

    task automatic test_tall_strip();
        set_grid(3, 4);
        fill_grid(3, 4, 1'b0);
        send_cell_cmd(plain_cmd(ACT_SWEEP, 0));
        send_cell_cmd(plain_cmd(ACT_READ, 1 + 2 * MAX_WIDTH));
        wait_drained();
    endtask

    task automatic random_phase(int n_items);
        int gw, gh, sel;
        gw = $urandom_range(3, 4);
        gh = $urandom_range(3, 4);
        case ($urandom_range(3))
            0: write_reg(CFG_RELAX, INV_BITS'($urandom_range(0, (1 << W_BITS) - 1)));
            default: write_reg(CFG_RELAX, INV_BITS'($urandom_range(1 << 24, 2 << 24)));
        endcase
        case ($urandom_range(4))
            0: write_reg(CFG_INV_SPACING, INV_BITS'({$urandom, $urandom}));
            1: write_reg(CFG_INV_SPACING, 47'd1 << $urandom_range(0, 46));
            default: write_reg(CFG_INV_SPACING, INV_BITS'($urandom_range(1, 3000)) << FRAC_BITS);
        endcase
        if ($urandom_range(5) == 0) begin
            set_grid($urandom_range(0, 2), gh);
        end else begin
            set_grid(gw, gh);
        end
        fill_grid(gw, gh, $urandom_range(3) == 0);
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                send_cell_cmd(write_cmd($urandom_range(1, gw - 2)
                    + $urandom_range(1, gh - 2) * MAX_WIDTH, $urandom_range(4) == 0));
            end else if (sel < 55) begin
                send_cell_cmd(plain_cmd(ACT_SWEEP, $urandom));
            end else if (sel < 85) begin
                read_any();
            end else if (sel < 92) begin
                send_cell_cmd(plain_cmd(ACT_UNUSED, $urandom));
            end else begin
                send_cell_cmd(write_cmd($urandom_range(0, CELLS - 1), 1'b1));
            end
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        stall_en = 1'b1;
        for (int p = 0; p < 2; p++) random_phase(4);
    endtask

    task automatic test_steady_stream();
        stall_en = 1'b0;
        random_phase(5);
        stall_en = 1'b1;
    endtask

    always @(posedge i_clk) begin
        cell_result_t exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (out_ch.read_value !== exp_r.rd) begin
                    $error("read_value exp %0h got %0h", exp_r.rd, out_ch.read_value);
                    errors++;
                end
                if (out_ch.sweep_norm !== exp_r.norm) begin
                    $error("sweep_norm exp %0h got %0h", exp_r.norm, out_ch.sweep_norm);
                    errors++;
                end
                if (out_ch.norm_saturated !== exp_r.sat) begin
                    $error("norm_saturated exp %0b got %0b", exp_r.sat,
                           out_ch.norm_saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        errors = 0;
        n_writes = 0;
        n_reads = 0;
        n_sweeps = 0;
        n_sat = 0;
        n_checked = 0;
        quiet_cycles = 0;
        stall_en = 1'b1;
        width_m = 7'd64;
        height_m = 7'd64;
        relax_m = 25'd29360128;
        inv_m = 47'd26843545600;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_wide_strip();
        test_extremes();
        test_tall_strip();
        test_random_phases();
        test_steady_stream();
        wait_drained();
        $display("covered %0d writes, %0d reads, %0d sweeps (%0d saturated)",
                 n_writes, n_reads, n_sweeps, n_sat);
        $display("%0d result beats checked, %0d mismatches", n_checked, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_in_if.sv
hw/rtl/rbs_out_if.sv
hw/rtl/rbs_ram.sv
hw/rtl/rbs_datapath.sv
hw/rtl/rbs_ctrl.sv
hw/rtl/red_black_sor_sweep.sv
tb/red_black_sor_sweep_tb.sv
